// ===== src/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender.
`default_nettype none
package gbn_pkg;

  // Sequence numbers, ack numbers and the frame count are all 16 bits wide
  localparam int SEQ_W = 16;
  // Burst length field: wide enough for the largest window the block supports (63)
  localparam int CNT_W = 7;
  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Event codes on in_action
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;
  localparam int WIN_CFG_W = 6;

  // One queued command: a run of count frames from fn, or the exit marker
  typedef struct packed {
    logic [SEQ_W-1:0] fn;
    logic [CNT_W-1:0] count;
    logic             is_exit;
  } cmd_t;

  // Session status from the front
  typedef struct packed {
    logic started;
    logic done;
  } sess_status_t;

endpackage
`default_nettype wire

// ===== src/gbn_cmd_fifo.sv =====
// Small flop-based command queue between front and back.
`default_nettype none
module gbn_cmd_fifo
  import gbn_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  input  wire  pop,
  output logic valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t               entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  fill_r;

  assign full     = (fill_r == CNT_QW'(DEPTH));
  assign valid    = (fill_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_QW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/gbn_front.sv =====
// Front end: config registers, session state and event classification.
`default_nettype none
module gbn_front
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [SEQ_W-1:0]      cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [1:0]            in_action,
  input  wire [SEQ_W-1:0]      in_ack_number,
  input  wire                  q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd,
  output sess_status_t         status
);

  localparam logic [CNT_W-1:0] MAX_WIN_C = CNT_W'(MAX_WINDOW);

  logic [SEQ_W-1:0]     frame_count_r;
  logic [WIN_CFG_W-1:0] window_size_r;

  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [SEQ_W-1:0] upper_r, upper_nxt;
  logic             started_r, started_nxt;
  logic             done_r, done_nxt;

  logic [SEQ_W-1:0] frames;
  logic [CNT_W-1:0] ws_ext, win;
  logic [SEQ_W-1:0] win16, base_inc, avail;
  logic [CNT_W-1:0] start_cnt, to_cnt;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign status    = '{started: started_r, done: done_r};

  // Effective frame count and window
  assign frames    = (frame_count_r == '0) ? SEQ_W'(1) : frame_count_r;
  assign ws_ext    = CNT_W'(window_size_r);
  assign win       = (window_size_r == '0) ? CNT_W'(1) :
                     ((ws_ext > MAX_WIN_C) ? MAX_WIN_C : ws_ext);
  assign win16     = SEQ_W'(win);
  assign base_inc  = base_r + SEQ_W'(1);
  assign start_cnt = (frames < win16) ? CNT_W'(frames) : win;
  assign avail     = frames - base_r;
  assign to_cnt    = (avail < win16) ? CNT_W'(avail) : win;

  always_comb begin
    base_nxt    = base_r;
    next_nxt    = next_r;
    upper_nxt   = upper_r;
    started_nxt = started_r;
    done_nxt    = done_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    if (accept && !done_r) begin
      unique case (in_action)
        ACT_START: begin
          if (!started_r) begin
            started_nxt   = 1'b1;
            base_nxt      = '0;
            upper_nxt     = win16 - SEQ_W'(1);
            next_nxt      = SEQ_W'(start_cnt);
            q_push        = 1'b1;
            q_cmd.fn      = '0;
            q_cmd.count   = start_cnt;
          end
        end
        ACT_ACK: begin
          if (started_r) begin
            priority if (in_ack_number == frames - SEQ_W'(1)) begin
              done_nxt      = 1'b1;
              q_push        = 1'b1;
              q_cmd.count   = CNT_W'(1);
              q_cmd.is_exit = 1'b1;
            end else if (in_ack_number == base_r) begin
              base_nxt = base_inc;
              if ((upper_r - base_inc) != (win16 - SEQ_W'(1)) && next_r < frames) begin
                q_push      = 1'b1;
                q_cmd.fn    = next_r;
                q_cmd.count = CNT_W'(1);
                upper_nxt   = upper_r + SEQ_W'(1);
                next_nxt    = next_r + SEQ_W'(1);
              end
            end else begin
              // not the base: ignored
            end
          end
        end
        ACT_TIMEOUT: begin
          if (started_r && base_r < frames) begin
            q_push      = 1'b1;
            q_cmd.fn    = base_r;
            q_cmd.count = to_cnt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= SEQ_W'(1);
      window_size_r <= WIN_CFG_W'(1);
      base_r        <= '0;
      next_r        <= '0;
      upper_r       <= '0;
      started_r     <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_FRAME_COUNT) begin
          frame_count_r <= cfg_wdata;
        end else begin
          window_size_r <= cfg_wdata[WIN_CFG_W-1:0];
        end
      end
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      upper_r   <= upper_nxt;
      started_r <= started_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/gbn_back.sv =====
// Back end: expands commands into one result per cycle when out_ready allows.
`default_nettype none
module gbn_back
  import gbn_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [SEQ_W-1:0] out_frame_number,
  output logic             out_is_exit,
  output logic             out_last
);

  logic             busy_r;
  logic [SEQ_W-1:0] cur_fn_r;
  logic [CNT_W-1:0] rem_r;
  logic             out_valid_r;
  logic [SEQ_W-1:0] out_fn_r;
  logic             out_exit_r, out_last_r;

  logic             src_valid, src_exit, fire, src_end;
  logic [SEQ_W-1:0] src_fn;
  logic [CNT_W-1:0] src_rem;

  // Continue the current run, else start on the queue head in the same cycle
  assign src_valid = busy_r || q_valid;
  assign src_fn    = busy_r ? cur_fn_r : q_cmd.fn;
  assign src_rem   = busy_r ? rem_r : q_cmd.count;
  assign src_exit  = !busy_r && q_cmd.is_exit;
  assign src_end   = (src_rem == CNT_W'(1));
  assign fire      = src_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire && !busy_r;

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_fn_r;
  assign out_is_exit      = out_exit_r;
  assign out_last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        busy_r      <= !src_end;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_fn_r   <= src_exit ? '0 : src_fn;
      out_exit_r <= src_exit;
      out_last_r <= src_end;
      cur_fn_r   <= src_fn + SEQ_W'(1);
      rem_r      <= src_rem - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== src/go_back_n_sender.sv =====
// Top level of the go-back-n sender: front end, command queue, back end.
//
// Go-Back-N sliding-window sender. Write frame_count (index 0) and window_size
// (index 1) while idle, then send a start event: frames 0 up to the window or
// frame count come out, one item per cycle, with last set on the final one.
// An ack equal to the window base moves the base and may release one new frame;
// an ack for frame_count-1 gives a single exit item (frame number 0) and ends
// the session until reset. A timeout resends the window from the base. Other
// acks, events before start and events after exit give nothing. Frame count 0
// counts as 1; window 0 counts as 1 and windows above MAX_WINDOW are clamped.
// Timing: the front takes one event per cycle while the two-entry command
// queue has room, so acks stream at one per cycle. The back end drains the
// queue at one result per cycle while out_ready is high, through a registered
// output, so a start or timeout keeps it busy for its whole burst; the queue
// fills behind a burst and in_ready then drops until the back end catches up.
// An accepted event's command passes through the queue and then the
// registered output before its first result appears.
`default_nettype none
module go_back_n_sender
  import gbn_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // configuration writes
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [SEQ_W-1:0]     cfg_wdata,
  // events in
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [1:0]           in_action,
  input  wire [SEQ_W-1:0]     in_ack_number,
  // frames out
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [SEQ_W-1:0]    out_frame_number,
  output logic                out_is_exit,
  output logic                out_last
);

  logic         q_push, q_full, q_pop, q_valid;
  cmd_t         q_in_cmd, q_head_cmd;
  sess_status_t sess;

  // Classifies events and keeps the window state; at most one command per event
  gbn_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_ack_number(in_ack_number),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in_cmd),
    .status       (sess)
  );

  // Decouples event intake from result output
  gbn_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_in_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_cmd(q_head_cmd)
  );

  // Turns each command into its run of result items
  gbn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_number(out_frame_number),
    .out_is_exit     (out_is_exit),
    .out_last        (out_last)
  );

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // Once the session has ended it stays ended
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sess.done |=> sess.done)
    else $error("session end flag cleared");

  // The exit marker is a single item carrying frame number zero
  a_exit_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_exit) |-> (out_last && out_frame_number == '0))
    else $error("malformed exit item");

  // Inside a burst the next frame follows at once and counts up by one
  a_burst_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && !out_is_exit &&
       out_frame_number == $past(out_frame_number) + SEQ_W'(1)))
    else $error("burst frame sequence broken");

endmodule
`default_nettype wire
